/* hdl/fpa_pkg.sv */
// Package for the fixed-point ALU: opcode codes, widths and the decoded word type.
// No dependencies; used by every module in hdl/.
`default_nettype none
package fpa_pkg;
    localparam int DataWidth = 32;
    localparam int FracBitsDefault = 8;
    localparam int QueueDepthDefault = 4;

    typedef enum logic [3:0] {
        CMD_ADD = 4'd0, CMD_SUB = 4'd1, CMD_MUL = 4'd2, CMD_DIV = 4'd3,
        CMD_GT = 4'd4, CMD_LT = 4'd5, CMD_GE = 4'd6, CMD_LE = 4'd7,
        CMD_EQ = 4'd8, CMD_NE = 4'd9, CMD_MIN = 4'd10, CMD_MAX = 4'd11,
        CMD_INC = 4'd12, CMD_DEC = 4'd13, CMD_I2F = 4'd14, CMD_F2I = 4'd15
    } cmd_t;

    // Operation class picked by the front end.
    typedef enum logic [1:0] {
        CLS_SIMPLE = 2'd0, CLS_MUL = 2'd1, CLS_DIV = 2'd2
    } cls_t;

    // One decoded word handed from front end to back end.
    typedef struct packed {
        cls_t                  cls;
        logic [DataWidth-1:0]  simple_value;
        logic                  compare_true;
        logic                  divide_by_zero;
        logic                  neg;
        logic [DataWidth-1:0]  mag_a;
        logic [DataWidth-1:0]  mag_b;
    } dec_t;
endpackage
`default_nettype wire

/* hdl/fpa_front.sv */
// Front end of the fixed-point ALU: decodes a word and computes the simple operations.
// Depends on fpa_pkg.
`default_nettype none
module fpa_front #(
    parameter int FRAC_BITS = fpa_pkg::FracBitsDefault
) (
    input  wire logic [3:0]                     cmd,
    input  wire logic signed [fpa_pkg::DataWidth-1:0] operand_a,
    input  wire logic signed [fpa_pkg::DataWidth-1:0] operand_b,
    output fpa_pkg::dec_t                       dec
);
    localparam int W = fpa_pkg::DataWidth;
    logic [W-1:0] ua, ub, mag_a, mag_b, f2i_mag;
    logic         a_gt_b, a_lt_b, a_eq_b;

    assign ua = operand_a;
    assign ub = operand_b;
    assign a_gt_b = operand_a > operand_b;
    assign a_lt_b = operand_a < operand_b;
    assign a_eq_b = operand_a == operand_b;
    assign mag_a = operand_a[W-1] ? (~ua + W'(1)) : ua;
    assign mag_b = operand_b[W-1] ? (~ub + W'(1)) : ub;
    assign f2i_mag = mag_a >> FRAC_BITS;

    always_comb begin
        dec = '0;
        dec.cls = fpa_pkg::CLS_SIMPLE;
        dec.mag_a = mag_a;
        dec.mag_b = mag_b;
        dec.neg = operand_a[W-1] ^ operand_b[W-1];
        case (fpa_pkg::cmd_t'(cmd))
            fpa_pkg::CMD_ADD: dec.simple_value = ua + ub;
            fpa_pkg::CMD_SUB: dec.simple_value = ua - ub;
            fpa_pkg::CMD_MUL: dec.cls = fpa_pkg::CLS_MUL;
            fpa_pkg::CMD_DIV: begin
                if (ub == '0) begin
                    dec.divide_by_zero = 1'b1;
                end else begin
                    dec.cls = fpa_pkg::CLS_DIV;
                end
            end
            fpa_pkg::CMD_GT: dec.compare_true = a_gt_b;
            fpa_pkg::CMD_LT: dec.compare_true = a_lt_b;
            fpa_pkg::CMD_GE: dec.compare_true = !a_lt_b;
            fpa_pkg::CMD_LE: dec.compare_true = !a_gt_b;
            fpa_pkg::CMD_EQ: dec.compare_true = a_eq_b;
            fpa_pkg::CMD_NE: dec.compare_true = !a_eq_b;
            fpa_pkg::CMD_MIN: dec.simple_value = a_gt_b ? ub : ua;
            fpa_pkg::CMD_MAX: dec.simple_value = a_gt_b ? ua : ub;
            fpa_pkg::CMD_INC: dec.simple_value = ua + W'(1);
            fpa_pkg::CMD_DEC: dec.simple_value = ua - W'(1);
            fpa_pkg::CMD_I2F: dec.simple_value = ua << FRAC_BITS;
            fpa_pkg::CMD_F2I: dec.simple_value =
                operand_a[W-1] ? (~f2i_mag + W'(1)) : f2i_mag;
            default: dec.simple_value = '0;
        endcase
    end
endmodule
`default_nettype wire

/* hdl/fpa_queue.sv */
// Small FIFO of decoded words between front end and back end.
// Depends on fpa_pkg.
`default_nettype none
module fpa_queue #(
    parameter int DEPTH = fpa_pkg::QueueDepthDefault
) (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          wr_valid,
    output logic               wr_ready,
    input  wire fpa_pkg::dec_t wr_data,
    output logic               rd_valid,
    input  wire logic          rd_ready,
    output fpa_pkg::dec_t      rd_data
);
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    fpa_pkg::dec_t    mem_reg [DEPTH];
    logic [AW-1:0]    wptr_reg, rptr_reg;
    logic [AW:0]      count_reg;
    logic             do_wr, do_rd;

    assign wr_ready = count_reg != (AW+1)'(DEPTH);
    assign rd_valid = count_reg != '0;
    assign rd_data  = mem_reg[rptr_reg];
    assign do_wr = wr_valid && wr_ready;
    assign do_rd = rd_valid && rd_ready;

    always_ff @(posedge aclk) begin
        if (do_wr) begin
            mem_reg[wptr_reg] <= wr_data;
        end
        if (!aresetn) begin
            wptr_reg <= '0;
            rptr_reg <= '0;
            count_reg <= '0;
        end else begin
            if (do_wr) begin
                wptr_reg <= (wptr_reg == AW'(DEPTH-1)) ? '0 : wptr_reg + AW'(1);
            end
            if (do_rd) begin
                rptr_reg <= (rptr_reg == AW'(DEPTH-1)) ? '0 : rptr_reg + AW'(1);
            end
            count_reg <= count_reg + (AW+1)'(do_wr) - (AW+1)'(do_rd);
        end
    end
endmodule
`default_nettype wire

/* hdl/fpa_back.sv */
// Back end of the fixed-point ALU: pipelined multiplier and divider, one word per cycle while not stalled.
// Depends on fpa_pkg.
`default_nettype none
module fpa_back #(
    parameter int FRAC_BITS = fpa_pkg::FracBitsDefault
) (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        in_valid,
    output logic                             in_ready,
    input  wire fpa_pkg::dec_t               in_data,
    output logic                             out_valid,
    input  wire logic                        out_ready,
    output logic [fpa_pkg::DataWidth-1:0]    out_value,
    output logic                             out_compare,
    output logic                             out_dz
);
    localparam int W  = fpa_pkg::DataWidth;
    localparam int NW = W + FRAC_BITS + 1;   // doubled numerator width
    localparam int DW = W + 2;               // doubled divisor plus sign room
    localparam int NS = NW + 1;              // stage 0 load, then one bit per stage

    // Per-stage control. Stage 0 is the input register; stage NS-1 holds the result.
    logic [NS-1:0]             v_reg;
    fpa_pkg::cls_t             cls_reg  [NS];
    logic [W-1:0]              sv_reg   [NS];
    logic                      cmp_reg  [NS];
    logic                      dz_reg   [NS];
    logic                      neg_reg  [NS];
    logic [NW-1:0]             num_reg  [NS];  // numerator shifting into quotient
    logic [DW-1:0]             rem_reg  [NS];
    logic [DW-1:0]             den_reg  [NS];
    logic [2*W-1:0]            prod_reg;
    logic                      adv;

    // The pipe moves as a whole when the last stage is empty or being taken.
    assign adv = !v_reg[NS-1] || out_ready;
    assign in_ready = adv;
    assign out_valid = v_reg[NS-1];

    // Product is formed in stage 0 from the magnitudes.
    always_ff @(posedge aclk) begin
        if (adv) begin
            prod_reg <= in_data.mag_a * in_data.mag_b;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else if (adv) begin
            v_reg <= {v_reg[NS-2:0], in_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            cls_reg[0] <= in_data.cls;
            sv_reg[0]  <= in_data.simple_value;
            cmp_reg[0] <= in_data.compare_true;
            dz_reg[0]  <= in_data.divide_by_zero;
            neg_reg[0] <= in_data.neg;
            // numerator 2*|a|<<F + |b|, divisor 2*|b|
            num_reg[0] <= (NW'(in_data.mag_a) << (FRAC_BITS + 1)) + NW'(in_data.mag_b);
            rem_reg[0] <= '0;
            den_reg[0] <= DW'(in_data.mag_b) << 1;
        end
    end

    for (genvar s = 1; s < NS; s++) begin : g_stage
        logic [DW-1:0] trial;
        logic          fits;
        logic [2*W-1:0] psum;
        assign trial = {rem_reg[s-1][DW-2:0], num_reg[s-1][NW-1]};
        assign fits  = trial >= den_reg[s-1];
        if (s == 1) begin : g_mul
            assign psum = prod_reg + (2*W)'(1 << (FRAC_BITS - 1));
        end else begin : g_nomul
            assign psum = '0;
        end
        always_ff @(posedge aclk) begin
            if (adv) begin
                cls_reg[s] <= cls_reg[s-1];
                cmp_reg[s] <= cmp_reg[s-1];
                dz_reg[s]  <= dz_reg[s-1];
                neg_reg[s] <= neg_reg[s-1];
                den_reg[s] <= den_reg[s-1];
                rem_reg[s] <= fits ? trial - den_reg[s-1] : trial;
                num_reg[s] <= {num_reg[s-1][NW-2:0], fits};
                if (s == 1 && cls_reg[0] == fpa_pkg::CLS_MUL) begin
                    sv_reg[s] <= W'(psum >> FRAC_BITS);
                end else if (s == NS - 1 && cls_reg[s-1] == fpa_pkg::CLS_DIV) begin
                    sv_reg[s] <= W'({num_reg[s-1][NW-2:0], fits});
                end else begin
                    sv_reg[s] <= sv_reg[s-1];
                end
            end
        end
    end

    always_comb begin
        out_compare = cmp_reg[NS-1];
        out_dz      = dz_reg[NS-1];
        case (cls_reg[NS-1])
            fpa_pkg::CLS_MUL, fpa_pkg::CLS_DIV: begin
                out_value = neg_reg[NS-1] ? (~sv_reg[NS-1] + W'(1)) : sv_reg[NS-1];
            end
            default: out_value = sv_reg[NS-1];
        endcase
    end
endmodule
`default_nettype wire

/* hdl/fixed_point_alu_core.sv */
// Top level of the fixed-point ALU: front end, decoded-word queue, pipelined back end.
// Depends on fpa_pkg, fpa_front, fpa_queue and fpa_back.
`default_nettype none
// This block takes one word per cycle while s_ready is high (opcode and two signed raw
// fixed-point operands with FRAC_BITS fraction bits) and returns exactly one result word for
// each, in order. Add, sub, comparisons, min, max, inc, dec and the conversions are decoded
// in the front end; multiply and divide run in the back end, where a restoring divider
// retires one quotient bit per pipeline stage. Every word is registered in the queue and
// then crosses the back-end pipeline of 34 + FRAC_BITS stages, counting its input register.
// The throughput is one word per cycle as long as m_ready stays high. Multiply and divide
// round half away from zero; divide by zero returns 0 with m_divide_by_zero set.
module fixed_point_alu_core #(
    parameter int FRAC_BITS   = fpa_pkg::FracBitsDefault,
    parameter int QUEUE_DEPTH = fpa_pkg::QueueDepthDefault
) (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire logic                                s_valid,
    output logic                                     s_ready,
    input  wire logic [3:0]                          s_cmd,
    input  wire logic signed [fpa_pkg::DataWidth-1:0] s_operand_a,
    input  wire logic signed [fpa_pkg::DataWidth-1:0] s_operand_b,
    output logic                                     m_valid,
    input  wire logic                                m_ready,
    output logic signed [fpa_pkg::DataWidth-1:0]     m_result_value,
    output logic                                     m_compare_true,
    output logic                                     m_divide_by_zero
);
    fpa_pkg::dec_t front_dec, q_dec;
    logic          q_valid, q_ready;
    logic [fpa_pkg::DataWidth-1:0] back_value;

    // The front end is pure decode; the queue registers its word.
    fpa_front #(.FRAC_BITS(FRAC_BITS)) u_front (
        .cmd(s_cmd), .operand_a(s_operand_a), .operand_b(s_operand_b), .dec(front_dec)
    );

    fpa_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
        .aclk(aclk), .aresetn(aresetn),
        .wr_valid(s_valid), .wr_ready(s_ready), .wr_data(front_dec),
        .rd_valid(q_valid), .rd_ready(q_ready), .rd_data(q_dec)
    );

    fpa_back #(.FRAC_BITS(FRAC_BITS)) u_back (
        .aclk(aclk), .aresetn(aresetn),
        .in_valid(q_valid), .in_ready(q_ready), .in_data(q_dec),
        .out_valid(m_valid), .out_ready(m_ready), .out_value(back_value),
        .out_compare(m_compare_true), .out_dz(m_divide_by_zero)
    );

    assign m_result_value = back_value;

    // A result word never carries both a compare flag and a divide-by-zero flag.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !(m_compare_true && m_divide_by_zero))
        else $error("compare and divide-by-zero flags both set");

    // A divide-by-zero word always reports a zero value.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_divide_by_zero) |-> (m_result_value == '0))
        else $error("divide-by-zero word with nonzero value");

    // A stalled result holds its value.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_result_value)))
        else $error("stalled result changed");
endmodule
`default_nettype wire

/* verif/fixed_point_alu_core_test.sv */
// Self-checking testbench for fixed_point_alu_core: directed corner words, random words
// under three idle patterns, and a long result-side stall. Depends on fpa_pkg and the RTL.
`timescale 1ns / 100ps
module fixed_point_alu_core_test;
    localparam int FRAC = fpa_pkg::FracBitsDefault;
    localparam int CYCLE_LIMIT = 400000;
    localparam logic signed [31:0] MAX_RAW = 32'sh7fffffff;
    localparam logic signed [31:0] MIN_RAW = 32'sh80000000;

    typedef struct {
        logic signed [31:0] value;
        bit                 cmp;
        bit                 dz;
    } alu_result_t;

    logic               aclk = 1'b0;
    logic               aresetn = 1'b0;
    logic               s_valid = 1'b0;
    logic               s_ready;
    logic [3:0]         s_cmd = fpa_pkg::CMD_ADD;
    logic signed [31:0] s_operand_a = '0;
    logic signed [31:0] s_operand_b = '0;
    logic               m_valid;
    logic               m_ready = 1'b0;
    logic signed [31:0] m_result_value;
    logic               m_compare_true;
    logic               m_divide_by_zero;

    // Results still owed by the block, oldest first.
    alu_result_t pending_results[$];
    int          mismatches = 0;
    int          cycles = 0;
    int          tx_idle_pct = 0;
    int          rx_idle_pct = 0;
    // Set by a test to stall the result side; counts down to zero while m_ready is held low.
    int          stall_left = 0;

    fixed_point_alu_core #(.FRAC_BITS(FRAC)) dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_cmd(s_cmd),
        .s_operand_a(s_operand_a), .s_operand_b(s_operand_b),
        .m_valid(m_valid), .m_ready(m_ready), .m_result_value(m_result_value),
        .m_compare_true(m_compare_true), .m_divide_by_zero(m_divide_by_zero)
    );

    always #4 aclk = ~aclk;

    // Exact integer version of every opcode; sums and shifts wrap at 32 bits, multiply and
    // divide round half away from zero on the magnitude and then restore the sign.
    function automatic alu_result_t predict_alu(fpa_pkg::cmd_t op, logic signed [31:0] a,
                                                logic signed [31:0] b);
        alu_result_t r;
        longint sa, sb, prod;
        longint unsigned mag, num, den, q;
        bit neg;
        r.value = '0;
        r.cmp = 1'b0;
        r.dz = 1'b0;
        sa = a;
        sb = b;
        case (op)
            fpa_pkg::CMD_ADD: r.value = a + b;
            fpa_pkg::CMD_SUB: r.value = a - b;
            fpa_pkg::CMD_MUL: begin
                prod = sa * sb;
                mag = (prod < 0) ? -prod : prod;
                q = (mag + (64'd1 << (FRAC - 1))) >> FRAC;
                r.value = (prod < 0) ? -q[31:0] : q[31:0];
            end
            fpa_pkg::CMD_DIV: begin
                if (sb == 0) begin
                    r.dz = 1'b1;
                end else begin
                    num = ((sa < 0) ? -sa : sa);
                    num = num << FRAC;
                    den = (sb < 0) ? -sb : sb;
                    q = (2 * num + den) / (2 * den);
                    neg = (sa < 0) != (sb < 0);
                    r.value = neg ? -q[31:0] : q[31:0];
                end
            end
            fpa_pkg::CMD_GT: r.cmp = a > b;
            fpa_pkg::CMD_LT: r.cmp = a < b;
            fpa_pkg::CMD_GE: r.cmp = a >= b;
            fpa_pkg::CMD_LE: r.cmp = a <= b;
            fpa_pkg::CMD_EQ: r.cmp = a == b;
            fpa_pkg::CMD_NE: r.cmp = a != b;
            fpa_pkg::CMD_MIN: r.value = (a > b) ? b : a;
            fpa_pkg::CMD_MAX: r.value = (a > b) ? a : b;
            fpa_pkg::CMD_INC: r.value = a + 1;
            fpa_pkg::CMD_DEC: r.value = a - 1;
            fpa_pkg::CMD_I2F: r.value = a << FRAC;
            default: begin
                // Fixed to int truncates toward zero, so shift the magnitude.
                mag = (sa < 0) ? -sa : sa;
                q = mag >> FRAC;
                r.value = (sa < 0) ? -q[31:0] : q[31:0];
            end
        endcase
        return r;
    endfunction

    // Offers one word and returns at the edge that accepts it. Valid is only lowered
    // while idling, so back-to-back words keep it high without a glitch.
    task automatic send_word(fpa_pkg::cmd_t op, logic signed [31:0] a, logic signed [31:0] b);
        if ($urandom_range(99) < tx_idle_pct) begin
            s_valid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(99) < tx_idle_pct);
        end
        s_valid <= 1'b1;
        s_cmd <= op;
        s_operand_a <= a;
        s_operand_b <= b;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        pending_results.push_back(predict_alu(op, a, b));
    endtask

    // Half full-range values, the rest small numbers and extremes, so that
    // rounding ties, equal operands and wraparound come up often.
    function automatic logic signed [31:0] pick_operand();
        case ($urandom_range(9))
            0: return MAX_RAW;
            1: return MIN_RAW;
            2, 3: return $signed($urandom_range(1024)) - 512;
            4: return $signed($urandom_range(65536)) - 32768;
            default: return $urandom;
        endcase
    endfunction

    task automatic send_random_words(int count);
        logic signed [31:0] a, b;
        fpa_pkg::cmd_t op;
        repeat (count) begin
            op = fpa_pkg::cmd_t'($urandom_range(15));
            a = pick_operand();
            b = ($urandom_range(7) == 0) ? a : pick_operand();
            if (op == fpa_pkg::CMD_DIV && $urandom_range(5) == 0) b = '0;
            send_word(op, a, b);
        end
    endtask

    task automatic test_directed();
        send_word(fpa_pkg::CMD_ADD, MAX_RAW, 32'sd1);
        send_word(fpa_pkg::CMD_SUB, MIN_RAW, 32'sd1);
        send_word(fpa_pkg::CMD_MUL, MIN_RAW, MIN_RAW);
        send_word(fpa_pkg::CMD_MUL, 32'sd1, 32'sd128);     // positive tie rounds up
        send_word(fpa_pkg::CMD_MUL, -32'sd1, 32'sd128);    // negative tie rounds away from zero
        send_word(fpa_pkg::CMD_MUL, MAX_RAW, -32'sd256);
        send_word(fpa_pkg::CMD_DIV, 32'sd300, 32'sd0);
        send_word(fpa_pkg::CMD_DIV, MIN_RAW, -32'sd1);
        send_word(fpa_pkg::CMD_DIV, -32'sd1, 32'sd512);
        send_word(fpa_pkg::CMD_DIV, MAX_RAW, MIN_RAW);
        send_word(fpa_pkg::CMD_GT, MAX_RAW, MIN_RAW);
        send_word(fpa_pkg::CMD_LT, MAX_RAW, MIN_RAW);
        send_word(fpa_pkg::CMD_GE, -32'sd5, -32'sd5);
        send_word(fpa_pkg::CMD_LE, 32'sd7, -32'sd7);
        send_word(fpa_pkg::CMD_EQ, MIN_RAW, MIN_RAW);
        send_word(fpa_pkg::CMD_NE, 32'sd0, 32'sd0);
        send_word(fpa_pkg::CMD_MIN, MIN_RAW, MAX_RAW);
        send_word(fpa_pkg::CMD_MAX, MIN_RAW, MAX_RAW);
        send_word(fpa_pkg::CMD_INC, MAX_RAW, 32'sd0);
        send_word(fpa_pkg::CMD_DEC, MIN_RAW, 32'sd0);
        send_word(fpa_pkg::CMD_I2F, MAX_RAW, 32'sd0);
        send_word(fpa_pkg::CMD_I2F, -32'sd3, 32'sd0);
        send_word(fpa_pkg::CMD_F2I, -32'sd1, 32'sd0);
        send_word(fpa_pkg::CMD_F2I, -32'sd257, 32'sd0);
        send_word(fpa_pkg::CMD_F2I, MAX_RAW, MIN_RAW);
    endtask

    task automatic test_random_idle_patterns();
        tx_idle_pct = 19;
        rx_idle_pct = 60;
        send_random_words(170);
        tx_idle_pct = 60;
        rx_idle_pct = 19;
        send_random_words(170);
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        send_random_words(170);
    endtask

    // The result side holds off long enough for the pipeline and queue to fill, so the
    // input side must drop s_ready while words keep being offered.
    task automatic test_output_stall();
        stall_left = 200;
        send_random_words(60);
    endtask

    // Result-side ready: random idling, overridden by a requested stall.
    always @(posedge aclk) begin
        if (stall_left > 0) begin
            m_ready <= 1'b0;
            stall_left <= stall_left - 1;
        end else begin
            m_ready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    // Compares every accepted result word against the oldest pending prediction.
    always @(posedge aclk) begin
        alu_result_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result word: value=%0d cmp=%0b dz=%0b",
                             m_result_value, m_compare_true, m_divide_by_zero);
            end else begin
                want = pending_results.pop_front();
                if (m_result_value !== want.value || m_compare_true !== want.cmp ||
                    m_divide_by_zero !== want.dz) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected value=%0d cmp=%0b dz=%0b, got %0d %0b %0b",
                                 want.value, want.cmp, want.dz, m_result_value,
                                 m_compare_true, m_divide_by_zero);
                end
            end
        end
    end

    // Watchdog on total run length.
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    initial begin
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed();
        test_random_idle_patterns();
        test_output_stall();
        s_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        // Wait on with a margin so that stray extra words are caught.
        repeat (60) @(posedge aclk);
        if (mismatches == 0 && pending_results.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end
endmodule
